/* rtl/core/assert_macros.svh */
// Assertion macros shared by the clipped color-key blit core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/ckb_pkg.sv */
// Shared types and constants of the clipped color-key blit core.
`default_nettype none
package ckb_pkg;

  localparam int unsigned MAX_SCREEN_DIM_DEF = 4096;
  localparam int unsigned ADDRESS_BITS_DEF   = 24;

  localparam int unsigned DIM_W    = 13;  // width of the screen size registers
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_KEY_ENABLE    = 3'd4;
  localparam logic [2:0] REG_KEY_COLOR     = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

  // Live configuration, screen sizes already clamped
  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
    logic               key_enable;
    logic [31:0]        key_color;
    logic [DIM_W-1:0]   screen_w;
    logic [DIM_W-1:0]   screen_h;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [31:0]      pixel;
    logic             write_ok;
    logic [DIM_W-1:0] px;
    logic [DIM_W-1:0] py;
    logic             last;
  } item_t;

endpackage
`default_nettype wire

/* rtl/core/ckb_front.sv */
// Front end: sprite counters, clipping and color-key classification.
`default_nettype none
`include "assert_macros.svh"
module ckb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ckb_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic [31:0]   source_pixel,
  output ckb_pkg::item_t     item
);

  logic [15:0] column_count;
  logic [15:0] row_count;
  logic [15:0] column_count_next;
  logic [15:0] row_count_next;

  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic               on_screen;
  logic               keyed;
  logic               row_end;
  logic               last;

  always_comb begin
    pos_x = 18'($signed(cfg.origin_x)) + $signed({2'b00, column_count});
    pos_y = 18'($signed(cfg.origin_y)) + $signed({2'b00, row_count});
    on_screen = !pos_x[17] && !pos_y[17] &&
                (pos_x[16:0] < {4'b0, cfg.screen_w}) &&
                (pos_y[16:0] < {4'b0, cfg.screen_h});
    keyed   = cfg.key_enable && (source_pixel == cfg.key_color);
    row_end = ({1'b0, column_count} + 17'd1) >= {1'b0, cfg.sprite_width};
    last    = row_end && (({1'b0, row_count} + 17'd1) >= {1'b0, cfg.sprite_height});

    item.pixel    = source_pixel;
    item.write_ok = on_screen && !keyed;
    item.px       = pos_x[ckb_pkg::DIM_W-1:0];
    item.py       = pos_y[ckb_pkg::DIM_W-1:0];
    item.last     = last;

    if (last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_count + 16'd1;
    end else begin
      column_count_next = column_count + 16'd1;
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  `ASSERT_CLK(a_clear, (accept && last) |=> {row_count, column_count} == '0, "counters not reset")

endmodule
`default_nettype wire

/* rtl/core/ckb_queue.sv */
// Short FIFO of classified pixels between front and back end.
`default_nettype none
`include "assert_macros.svh"
module ckb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ckb_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output ckb_pkg::item_t      head,
  output logic                empty
);

  localparam int unsigned DEPTH = ckb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  ckb_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  `ASSERT_CLK(a_count_bound, count <= (PTR_W+1)'(DEPTH), "queue count beyond depth")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule
`default_nettype wire

/* rtl/core/ckb_back.sv */
// Back end: destination address and the result register.
`default_nettype none
`include "assert_macros.svh"
module ckb_back #(
  parameter int unsigned ADDRESS_BITS = ckb_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ckb_pkg::DIM_W-1:0] screen_w,
  input  wire ckb_pkg::item_t           q_head,
  input  wire logic                     q_empty,
  output logic                          q_pop,
  input  wire logic                     pop,
  output logic                          empty,
  output logic                          write_enable,
  output logic [ADDRESS_BITS-1:0]       pixel_address,
  output logic [31:0]                   pixel_color,
  output logic                          last_pixel
);

  logic                    out_valid;
  logic [2*ckb_pkg::DIM_W-1:0] row_base;
  logic [31:0]             addr_sum;

  assign empty = !out_valid;
  assign q_pop = !q_empty && (!out_valid || pop);

  always_comb begin
    row_base = {{ckb_pkg::DIM_W{1'b0}}, q_head.py} * {{ckb_pkg::DIM_W{1'b0}}, screen_w};
    addr_sum = 32'(row_base) + 32'(q_head.px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      write_enable  <= q_head.write_ok;
      pixel_address <= q_head.write_ok ? addr_sum[ADDRESS_BITS-1:0] : '0;
      pixel_color   <= q_head.pixel;
      last_pixel    <= q_head.last;
    end
  end

  `ASSERT_CLK(a_fill_output, (!q_empty && !out_valid) |=> out_valid, "output register not filled")

endmodule
`default_nettype wire

/* rtl/core/clipped_color_key_blit_core.sv */
// Top level of the clipped color-key blit core.
//
// Usage: write the sprite origin, sprite size, color key and screen size
// through the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while
// the core is idle; cfg_ready is always high. Then stream the sprite's
// source pixels in row-major order with push/full. Every pixel yields one
// result transaction, taken with pop/empty: write_enable, pixel_address
// (row * screen_width + column), pixel_color and last_pixel on the final
// pixel of the sprite, after which the counters start over.
// A pushed pixel is written into the queue, and then into the output register
// once that register is free. Throughput: one pixel per cycle while pop keeps
// up, set by the combinational classify in the front end and the one
// multiply-add per cycle in the back end. A four-entry queue parts the two
// ends, and an output register holds the result: when pop stays low, the
// queue fills and full rises; nothing is dropped. Reset (rst, synchronous)
// clears the counters, queue and output valid flag, and loads the register
// reset values (origin 0,0; sprite 1x1; key off, key 0; screen 1024x768).
`default_nettype none
module clipped_color_key_blit_core #(
  parameter int unsigned MAX_SCREEN_DIM = ckb_pkg::MAX_SCREEN_DIM_DEF,
  parameter int unsigned ADDRESS_BITS   = ckb_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // source pixel channel
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [31:0]            source_pixel,
  // result channel
  input  wire logic                   pop,
  output logic                        empty,
  output logic                        write_enable,
  output logic [ADDRESS_BITS-1:0]     pixel_address,
  output logic [31:0]                 pixel_color,
  output logic                        last_pixel,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam logic [ckb_pkg::DIM_W-1:0] DIM_LIMIT = ckb_pkg::DIM_W'(MAX_SCREEN_DIM);

  // Configuration registers
  logic signed [15:0]          origin_x;
  logic signed [15:0]          origin_y;
  logic [15:0]                 sprite_width;
  logic [15:0]                 sprite_height;
  logic                        key_enable;
  logic [31:0]                 key_color;
  logic [ckb_pkg::DIM_W-1:0]   screen_width;
  logic [ckb_pkg::DIM_W-1:0]   screen_height;

  ckb_pkg::cfg_t  cfg;
  ckb_pkg::item_t front_item;
  ckb_pkg::item_t q_head;
  logic           in_accept;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= 16'd1;
      sprite_height <= 16'd1;
      key_enable    <= 1'b0;
      key_color     <= '0;
      screen_width  <= ckb_pkg::DIM_W'(1024);
      screen_height <= ckb_pkg::DIM_W'(768);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ckb_pkg::REG_ORIGIN_X:      origin_x      <= $signed(cfg_data[15:0]);
        ckb_pkg::REG_ORIGIN_Y:      origin_y      <= $signed(cfg_data[15:0]);
        ckb_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[15:0];
        ckb_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data[15:0];
        ckb_pkg::REG_KEY_ENABLE:    key_enable    <= cfg_data[0];
        ckb_pkg::REG_KEY_COLOR:     key_color     <= cfg_data;
        ckb_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[ckb_pkg::DIM_W-1:0];
        ckb_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[ckb_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturate the screen size to the largest supported dimension
  always_comb begin
    cfg.origin_x      = origin_x;
    cfg.origin_y      = origin_y;
    cfg.sprite_width  = sprite_width;
    cfg.sprite_height = sprite_height;
    cfg.key_enable    = key_enable;
    cfg.key_color     = key_color;
    cfg.screen_w      = (screen_width > DIM_LIMIT) ? DIM_LIMIT : screen_width;
    cfg.screen_h      = (screen_height > DIM_LIMIT) ? DIM_LIMIT : screen_height;
  end

  // Take a pixel whenever the queue has room
  assign in_accept = push && !full;

  ckb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (in_accept),
    .source_pixel (source_pixel),
    .item         (front_item)
  );

  ckb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_item (front_item),
    .full      (full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ckb_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_w      (cfg.screen_w),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .write_enable  (write_enable),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

endmodule
`default_nettype wire
